### design/bfc_pkg.sv
// bfc_pkg: shared types and constants for the box/frustum classifier.
// Used by bfc_cell, bfc_eval and box_frustum_classify. No dependencies.
package bfc_pkg;

    // Width of every coordinate and coefficient field on the ports
    localparam int FIELD_W = 32;
    // Width of the plane index field
    localparam int INDEX_W = 3;
    // Corners of a box, and the width of a per-plane corner count (0..8)
    localparam int CORNERS = 8;
    localparam int COUNT_W = 4;

    // Item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TEST  = 1'b1;

    // Classification codes
    localparam logic [1:0] CLASS_OUTSIDE = 2'd0;
    localparam logic [1:0] CLASS_CROSS   = 2'd1;
    localparam logic [1:0] CLASS_INSIDE  = 2'd2;

    // Tag travelling with each plane through the evaluator pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } bfc_tag_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } bfc_state_t;

endpackage

### design/box_frustum_classify.sv
// box_frustum_classify: axis-aligned box against view-frustum classifier.
// A box test rotates the planes past the evaluator one per cycle into its 3
// evaluator stages, then registers the class word; the next word is taken
// only once back in idle, so each box finishes before another is accepted.
// A result word held by the receiver stalls the emit. One plane write per
// cycle while idle. Reset clears all planes to zero, the pipeline tags and
// the output valid flag.
module box_frustum_classify #(
    parameter int NUM_PLANES  = 6,
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                func,
    input  logic [bfc_pkg::INDEX_W-1:0]         plane_index,
    input  logic signed [bfc_pkg::FIELD_W-1:0]  coef_a,
    input  logic signed [bfc_pkg::FIELD_W-1:0]  coef_b,
    input  logic signed [bfc_pkg::FIELD_W-1:0]  coef_c,
    input  logic signed [bfc_pkg::FIELD_W-1:0]  coef_d,
    input  logic signed [bfc_pkg::FIELD_W-1:0]  min_x,
    input  logic signed [bfc_pkg::FIELD_W-1:0]  min_y,
    input  logic signed [bfc_pkg::FIELD_W-1:0]  min_z,
    input  logic signed [bfc_pkg::FIELD_W-1:0]  max_x,
    input  logic signed [bfc_pkg::FIELD_W-1:0]  max_y,
    input  logic signed [bfc_pkg::FIELD_W-1:0]  max_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          classification
);
    import bfc_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int CNT_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    bfc_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [3*CW-1:0]  lo_reg, lo_next;
    logic [3*CW-1:0]  hi_reg, hi_next;
    logic             outside_reg, outside_next;
    logic             allin_reg, allin_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       class_reg, class_next;

    logic             in_fire;
    logic             is_test;
    logic             idx_ok;
    logic             issue_last;
    logic             emit_fire;
    logic             shift_en;
    bfc_tag_t         ev_tag_in;
    bfc_tag_t         ev_tag_out;
    logic [COUNT_W-1:0] ev_count;
    logic [4*CW-1:0]  wr_plane;
    logic [4*CW-1:0]  ring [NUM_PLANES];

    assign in_fire    = in_valid && in_ready;
    assign is_test    = (func == FUNC_TEST);
    assign idx_ok     = ({1'b0, plane_index} < (INDEX_W+1)'(NUM_PLANES));
    assign issue_last = (cnt_reg == CNT_W'(NUM_PLANES - 1));
    assign wr_plane   = {coef_a[CW-1:0], coef_b[CW-1:0], coef_c[CW-1:0], coef_d[CW-1:0]};

    // Plane ring: cell i takes its neighbour's plane, cell 0 feeds the evaluator
    for (genvar g = 0; g < NUM_PLANES; g++)
    begin : g_ring
        bfc_cell #(
            .COORD_WIDTH (CW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (shift_en),
            .wr_en    (in_fire && !is_test && idx_ok && (plane_index == INDEX_W'(g))),
            .wr_plane (wr_plane),
            .nb_plane (ring[(g + 1) % NUM_PLANES]),
            .plane    (ring[g])
        );
    end

    // Evaluator
    bfc_eval #(
        .COORD_WIDTH (CW),
        .FRAC_BITS   (FRAC_BITS)
    ) u_eval (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (ev_tag_in),
        .plane   (ring[0]),
        .box_lo  (lo_reg),
        .box_hi  (hi_reg),
        .tag_out (ev_tag_out),
        .count   (ev_count)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && is_test)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (ev_tag_out.valid && ev_tag_out.last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready        = (state_reg == ST_IDLE);
        shift_en        = (state_reg == ST_ISSUE);
        ev_tag_in.valid = (state_reg == ST_ISSUE);
        ev_tag_in.last  = (state_reg == ST_ISSUE) && issue_last;
        emit_fire       = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    end

    // Issue counter, box capture and per-plane accumulation
    always_comb
    begin
        cnt_next     = cnt_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        outside_next = outside_reg;
        allin_next   = allin_reg;
        if (in_fire && is_test)
        begin
            cnt_next     = '0;
            lo_next      = {min_x[CW-1:0], min_y[CW-1:0], min_z[CW-1:0]};
            hi_next      = {max_x[CW-1:0], max_y[CW-1:0], max_z[CW-1:0]};
            outside_next = 1'b0;
            allin_next   = 1'b1;
        end
        else if (shift_en && !issue_last)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (ev_tag_out.valid)
        begin
            if (ev_count == '0)
            begin
                outside_next = 1'b1;
            end
            if (ev_count != COUNT_W'(CORNERS))
            begin
                allin_next = 1'b0;
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        class_next     = class_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
            if (outside_reg)
            begin
                class_next = CLASS_OUTSIDE;
            end
            else if (allin_reg)
            begin
                class_next = CLASS_INSIDE;
            end
            else
            begin
                class_next = CLASS_CROSS;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            outside_reg   <= 1'b0;
            allin_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            outside_reg   <= outside_next;
            allin_reg     <= allin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        class_reg <= class_next;
    end

    assign out_valid      = out_valid_reg;
    assign classification = class_reg;

    // No plane in flight while parked
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ev_tag_out.valid)
        else $error("evaluator busy while idle");

    // Final plane only leaves the evaluator while draining
    a_last_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (ev_tag_out.valid && ev_tag_out.last) |-> (state_reg == ST_DRAIN))
        else $error("last plane outside drain");

    // A result word only appears out of the emit state
    a_rose_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result without emit");

    // One plane cannot have zero and all corners in front
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !(outside_reg && allin_reg))
        else $error("outside and inside both set");

    // Only legal classification codes
    a_class_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (class_reg == CLASS_OUTSIDE || class_reg == CLASS_CROSS
                           || class_reg == CLASS_INSIDE))
        else $error("bad classification");

endmodule

### design/bfc_cell.sv
// bfc_cell: one cell of the plane ring; holds one plane {a,b,c,d}.
// Loads a new plane on write, or takes its neighbour's plane on shift.
// Depends on bfc_pkg.
module bfc_cell #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       shift,
    input  logic                       wr_en,
    input  logic [4*COORD_WIDTH-1:0]   wr_plane,
    input  logic [4*COORD_WIDTH-1:0]   nb_plane,
    output logic [4*COORD_WIDTH-1:0]   plane
);
    import bfc_pkg::*;

    logic [4*COORD_WIDTH-1:0] plane_reg;
    logic [4*COORD_WIDTH-1:0] plane_next;

    // Shift has priority; writes only happen while the ring is parked
    always_comb
    begin
        plane_next = plane_reg;
        if (shift)
        begin
            plane_next = nb_plane;
        end
        else if (wr_en)
        begin
            plane_next = wr_plane;
        end
    end

    // Plane store clears to a zero plane
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
        end
        else
        begin
            plane_reg <= plane_next;
        end
    end

    assign plane = plane_reg;

endmodule

### design/bfc_eval.sv
// bfc_eval: three-stage plane evaluator. Takes one plane and the box,
// returns how many of the 8 corners lie strictly in front of the plane.
// Depends on bfc_pkg.
module bfc_eval #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bfc_pkg::bfc_tag_t             tag_in,
    input  logic [4*COORD_WIDTH-1:0]      plane,
    input  logic [3*COORD_WIDTH-1:0]      box_lo,
    input  logic [3*COORD_WIDTH-1:0]      box_hi,
    output bfc_pkg::bfc_tag_t             tag_out,
    output logic [bfc_pkg::COUNT_W-1:0]   count
);
    import bfc_pkg::*;

    localparam int PROD_W = 2 * COORD_WIDTH;
    localparam int DQ_W   = COORD_WIDTH + FRAC_BITS;
    localparam int SUM_W  = ((PROD_W > DQ_W) ? PROD_W : DQ_W) + 2;

    logic signed [COORD_WIDTH-1:0] ca, cb, cc, cd;
    logic signed [COORD_WIDTH-1:0] lx, ly, lz, hx, hy, hz;

    // Stage 1: products, Q32.32
    logic signed [PROD_W-1:0] px_reg [2];
    logic signed [PROD_W-1:0] py_reg [2];
    logic signed [PROD_W-1:0] pz_reg [2];
    logic signed [DQ_W-1:0]   dq_reg;
    logic signed [PROD_W-1:0] px_next [2];
    logic signed [PROD_W-1:0] py_next [2];
    logic signed [PROD_W-1:0] pz_next [2];
    logic signed [DQ_W-1:0]   dq_next;
    bfc_tag_t                 tag1_reg;

    // Stage 2: pair sums
    logic signed [SUM_W-1:0]  sxd_reg [2];
    logic signed [SUM_W-1:0]  syz_reg [4];
    logic signed [SUM_W-1:0]  sxd_next [2];
    logic signed [SUM_W-1:0]  syz_next [4];
    bfc_tag_t                 tag2_reg;

    // Stage 3: corner count
    logic signed [SUM_W-1:0]  corner [CORNERS];
    logic [CORNERS-1:0]       front;
    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;
    bfc_tag_t                 tag3_reg;

    // Unpack plane and box
    assign ca = $signed(plane[4*COORD_WIDTH-1:3*COORD_WIDTH]);
    assign cb = $signed(plane[3*COORD_WIDTH-1:2*COORD_WIDTH]);
    assign cc = $signed(plane[2*COORD_WIDTH-1:COORD_WIDTH]);
    assign cd = $signed(plane[COORD_WIDTH-1:0]);
    assign lx = $signed(box_lo[3*COORD_WIDTH-1:2*COORD_WIDTH]);
    assign ly = $signed(box_lo[2*COORD_WIDTH-1:COORD_WIDTH]);
    assign lz = $signed(box_lo[COORD_WIDTH-1:0]);
    assign hx = $signed(box_hi[3*COORD_WIDTH-1:2*COORD_WIDTH]);
    assign hy = $signed(box_hi[2*COORD_WIDTH-1:COORD_WIDTH]);
    assign hz = $signed(box_hi[COORD_WIDTH-1:0]);

    // Stage 1 logic: six products and d aligned to the product scale
    always_comb
    begin
        px_next[0] = PROD_W'(ca) * PROD_W'(lx);
        px_next[1] = PROD_W'(ca) * PROD_W'(hx);
        py_next[0] = PROD_W'(cb) * PROD_W'(ly);
        py_next[1] = PROD_W'(cb) * PROD_W'(hy);
        pz_next[0] = PROD_W'(cc) * PROD_W'(lz);
        pz_next[1] = PROD_W'(cc) * PROD_W'(hz);
        dq_next    = $signed({cd, {FRAC_BITS{1'b0}}});
    end

    // Stage 2 logic: x plus d, and y plus z for each corner pair
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            sxd_next[i] = SUM_W'(px_reg[i]) + SUM_W'(dq_reg);
        end
        for (int j = 0; j < 2; j++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                syz_next[2*j+k] = SUM_W'(py_reg[j]) + SUM_W'(pz_reg[k]);
            end
        end
    end

    // Stage 3 logic: final sums, strict sign test, population count
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            for (int m = 0; m < 4; m++)
            begin
                corner[4*i+m] = sxd_reg[i] + syz_reg[m];
                front[4*i+m]  = !corner[4*i+m][SUM_W-1] && (|corner[4*i+m]);
            end
        end
        count_next = COUNT_W'($countones(front));
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        pz_reg    <= pz_next;
        dq_reg    <= dq_next;
        sxd_reg   <= sxd_next;
        syz_reg   <= syz_next;
        count_reg <= count_next;
    end

    // Tag pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    assign tag_out = tag3_reg;
    assign count   = count_reg;

endmodule

### tb/box_frustum_classify_tb.sv
// box_frustum_classify_tb: self-checking bench for the box/frustum classifier.
// Predicts each class word from its own plane store and checks the words in
// order under random idling on both sides. Depends on bfc_pkg and the design.
module box_frustum_classify_tb;

    import bfc_pkg::*;

    localparam int NUM_PLANES   = 6;
    localparam int FRAC_BITS    = 16;
    localparam int ITEM_GOAL    = 1050;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4 * (NUM_PLANES + 4);
    localparam int ONE          = 1 << FRAC_BITS;

    // One input word as the bench sees it
    typedef struct {
        logic                      func;
        logic [INDEX_W-1:0]        plane_index;
        logic signed [FIELD_W-1:0] coef_a, coef_b, coef_c, coef_d;
        logic signed [FIELD_W-1:0] min_x, min_y, min_z;
        logic signed [FIELD_W-1:0] max_x, max_y, max_z;
    } cull_item_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      func = FUNC_WRITE;
    logic [INDEX_W-1:0]        plane_index = '0;
    logic signed [FIELD_W-1:0] coef_a = '0, coef_b = '0, coef_c = '0, coef_d = '0;
    logic signed [FIELD_W-1:0] min_x = '0, min_y = '0, min_z = '0;
    logic signed [FIELD_W-1:0] max_x = '0, max_y = '0, max_z = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [1:0]                classification;

    // Predictor state: the planes as the block should hold them
    logic signed [FIELD_W-1:0] plane_a [NUM_PLANES] = '{default: '0};
    logic signed [FIELD_W-1:0] plane_b [NUM_PLANES] = '{default: '0};
    logic signed [FIELD_W-1:0] plane_c [NUM_PLANES] = '{default: '0};
    logic signed [FIELD_W-1:0] plane_d [NUM_PLANES] = '{default: '0};

    cull_item_t pending_items[$];
    cull_item_t cur_item;
    logic [1:0] expected_class[$];
    int         items_taken = 0;
    int         total_items = 0;
    int         mismatches = 0;
    int         quiet_cycles = 0;

    box_frustum_classify dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .plane_index    (plane_index),
        .coef_a         (coef_a),
        .coef_b         (coef_b),
        .coef_c         (coef_c),
        .coef_d         (coef_d),
        .min_x          (min_x),
        .min_y          (min_y),
        .min_z          (min_z),
        .max_x          (max_x),
        .max_y          (max_y),
        .max_z          (max_z),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .classification (classification)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Idling pattern: sender-light first, then swapped, then none at all
    function automatic int sender_idle_pct();
        if (items_taken < total_items / 3)
            return 34;
        else if (items_taken < 2 * total_items / 3)
            return 61;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (items_taken < total_items / 3)
            return 61;
        else if (items_taken < 2 * total_items / 3)
            return 34;
        return 0;
    endfunction

    // Class of a box against the stored planes; sums are exact in 128 bits
    function automatic logic [1:0] classify_box(cull_item_t it);
        logic signed [63:0]  px [2];
        logic signed [63:0]  py [2];
        logic signed [63:0]  pz [2];
        logic signed [63:0]  dq;
        logic signed [127:0] acc;
        int                  front;
        int                  total;
        logic                clear_of_plane;
        total = 0;
        clear_of_plane = 1'b0;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            px[0] = plane_a[p] * it.min_x;
            px[1] = plane_a[p] * it.max_x;
            py[0] = plane_b[p] * it.min_y;
            py[1] = plane_b[p] * it.max_y;
            pz[0] = plane_c[p] * it.min_z;
            pz[1] = plane_c[p] * it.max_z;
            dq = plane_d[p];
            dq = dq <<< FRAC_BITS;
            front = 0;
            for (int i = 0; i < 2; i++)
                for (int j = 0; j < 2; j++)
                    for (int k = 0; k < 2; k++)
                    begin
                        acc = px[i] + py[j] + pz[k] + dq;
                        if (acc > 0)
                            front++;
                    end
            if (front == 0)
                clear_of_plane = 1'b1;
            total += front;
        end
        if (clear_of_plane)
            return CLASS_OUTSIDE;
        else if (total == CORNERS * NUM_PLANES)
            return CLASS_INSIDE;
        return CLASS_CROSS;
    endfunction

    // Update the plane store or queue the class word for one accepted item
    task automatic predict_item(cull_item_t it);
        if (it.func == FUNC_WRITE)
        begin
            // out-of-range indexes are dropped
            if (it.plane_index < NUM_PLANES)
            begin
                plane_a[it.plane_index] = it.coef_a;
                plane_b[it.plane_index] = it.coef_b;
                plane_c[it.plane_index] = it.coef_c;
                plane_d[it.plane_index] = it.coef_d;
            end
        end
        else
            expected_class.insert(expected_class.size(), classify_box(it));
    endtask

    task automatic note_error(string what, logic [1:0] want, logic [1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected class %0d, got %0d", $time, what, want, got);
    endtask

    // Stimulus builders; the unused half of each word carries random bits
    task automatic queue_plane(int idx, int a, int b, int c, int d);
        cull_item_t it;
        it.func = FUNC_WRITE;
        it.plane_index = idx[INDEX_W-1:0];
        it.coef_a = a;
        it.coef_b = b;
        it.coef_c = c;
        it.coef_d = d;
        it.min_x = $urandom;
        it.min_y = $urandom;
        it.min_z = $urandom;
        it.max_x = $urandom;
        it.max_y = $urandom;
        it.max_z = $urandom;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic queue_box(int lx, int ly, int lz, int hx, int hy, int hz);
        cull_item_t it;
        it.func = FUNC_TEST;
        it.plane_index = INDEX_W'($urandom_range(7));
        it.coef_a = $urandom;
        it.coef_b = $urandom;
        it.coef_c = $urandom;
        it.coef_d = $urandom;
        it.min_x = lx;
        it.min_y = ly;
        it.min_z = lz;
        it.max_x = hx;
        it.max_y = hy;
        it.max_z = hz;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic queue_noise();
        cull_item_t it;
        it.func = 1'($urandom_range(1));
        it.plane_index = INDEX_W'($urandom_range(7));
        it.coef_a = $urandom;
        it.coef_b = $urandom;
        it.coef_c = $urandom;
        it.coef_d = $urandom;
        it.min_x = $urandom;
        it.min_y = $urandom;
        it.min_z = $urandom;
        it.max_x = $urandom;
        it.max_y = $urandom;
        it.max_z = $urandom;
        pending_items.insert(pending_items.size(), it);
    endtask

    // Driver: presents pending words, holds each until it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_item(cur_item);
                items_taken <= items_taken + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct())
                begin
                    cur_item = pending_items.pop_front();
                    in_valid    <= 1'b1;
                    func        <= cur_item.func;
                    plane_index <= cur_item.plane_index;
                    coef_a      <= cur_item.coef_a;
                    coef_b      <= cur_item.coef_b;
                    coef_c      <= cur_item.coef_c;
                    coef_d      <= cur_item.coef_d;
                    min_x       <= cur_item.min_x;
                    min_y       <= cur_item.min_y;
                    min_z       <= cur_item.min_z;
                    max_x       <= cur_item.max_x;
                    max_y       <= cur_item.max_y;
                    max_z       <= cur_item.max_z;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each class word against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_class.size() == 0)
                    note_error("word with none expected", 2'bxx, classification);
                else if (classification !== expected_class[0])
                    note_error("class mismatch", expected_class.pop_front(), classification);
                else
                    void'(expected_class.pop_front());
            end
            out_ready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int ext [3];
        int cen;
        int half;
        int lo [3];
        int hi [3];
        int coef [3];
        int scale;
        int rot;
        int nbox;
        int tmp;
        logic partial;

        // Directed: untouched planes are all zero, so any box is outside
        queue_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_box(0, 0, 0, 0, 0, 0);
        // writes beyond the last plane are dropped
        queue_plane(6, ONE, ONE, ONE, 100 * ONE);
        queue_plane(7, -ONE, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        // cube frustum of half-size 100
        queue_plane(0, ONE, 0, 0, 100 * ONE);
        queue_plane(1, -ONE, 0, 0, 100 * ONE);
        queue_plane(2, 0, ONE, 0, 100 * ONE);
        queue_plane(3, 0, -ONE, 0, 100 * ONE);
        queue_plane(4, 0, 0, ONE, 100 * ONE);
        queue_plane(5, 0, 0, -ONE, 100 * ONE);
        queue_box(-10 * ONE, -10 * ONE, -10 * ONE, 10 * ONE, 10 * ONE, 10 * ONE);
        queue_box(50 * ONE, 0, 0, 150 * ONE, ONE, ONE);
        queue_box(200 * ONE, 0, 0, 300 * ONE, ONE, ONE);
        // corners lying exactly on a plane do not count as in front
        queue_box(-100 * ONE, 0, 0, -50 * ONE, ONE, ONE);
        queue_box(-120 * ONE, 0, 0, -100 * ONE, ONE, ONE);
        // min above max is taken as given
        queue_box(10 * ONE, 10 * ONE, 10 * ONE, -10 * ONE, -10 * ONE, -10 * ONE);
        queue_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        // extreme coefficients against extreme and degenerate boxes
        queue_plane(5, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        queue_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_box(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                  32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        queue_box(0, 0, 0, 0, 0, 0);
        queue_plane(5, 0, 0, 0, 0);
        queue_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);

        // Random: mostly frustum set-ups followed by boxes, some noise
        while (pending_items.size() < ITEM_GOAL)
        begin
            if ($urandom_range(99) < 85)
            begin
                partial = ($urandom_range(99) < 15);
                rot = $urandom_range(NUM_PLANES - 1);
                for (int ax = 0; ax < 3; ax++)
                    ext[ax] = $urandom_range(200) * ONE + $urandom_range(ONE - 1);
                for (int i = 0; i < NUM_PLANES; i++)
                begin
                    if (!(partial && $urandom_range(99) < 30))
                    begin
                        scale = $urandom_range(3, 1);
                        for (int ax = 0; ax < 3; ax++)
                            coef[ax] = ($urandom_range(1) == 1)
                                       ? int'($urandom_range(ONE / 2)) - ONE / 4 : 0;
                        coef[i / 2] = ((i % 2) == 1) ? -scale * ONE : scale * ONE;
                        queue_plane((rot + i) % NUM_PLANES, coef[0], coef[1], coef[2],
                                    scale * ext[i / 2]);
                    end
                    if ($urandom_range(99) < 5)
                        queue_plane($urandom_range(7, NUM_PLANES), $urandom, $urandom,
                                    $urandom, $urandom);
                end
                nbox = $urandom_range(14, 4);
                for (int n = 0; n < nbox; n++)
                begin
                    for (int ax = 0; ax < 3; ax++)
                    begin
                        cen = int'($urandom_range(3 * ext[ax])) - 3 * ext[ax] / 2;
                        half = $urandom_range(60 * ONE);
                        lo[ax] = cen - half;
                        hi[ax] = cen + half;
                        if ($urandom_range(99) < 8)
                        begin
                            tmp = lo[ax];
                            lo[ax] = hi[ax];
                            hi[ax] = tmp;
                        end
                    end
                    if ($urandom_range(99) < 5)
                        queue_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                    else
                        queue_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
                end
            end
            else
                repeat ($urandom_range(6, 2)) queue_noise();
        end
        total_items = pending_items.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every word to go in and every class word to come back
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_class.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_class.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
